[hw/rtl/rsp_pkg.sv]
// ---------------------------------------------------------------------------
// rsp_pkg
// Types, constants and helpers shared by the rain/snow partition pipeline.
// ---------------------------------------------------------------------------
package rsp_pkg;

  localparam int TempW        = 16;
  localparam int AmtW         = 32;
  localparam int MuW          = 16;
  localparam int MinW         = 20;
  localparam int FracW        = 17;  // Q1.16 fraction, 0..65536
  localparam int QuoW         = 16;
  localparam int DivW         = 19;  // divisor / remainder width
  localparam int BitsPerStage = 2;
  localparam int DivStages    = QuoW / BitsPerStage;
  localparam int PolyW        = 22;  // signed S-curve sum

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegUpper = 2'd1;
  localparam logic [1:0] RegLower = 2'd2;
  localparam logic [1:0] RegMin   = 2'd3;

  localparam logic [FracW-1:0] FracOne    = 17'h10000;
  localparam logic [PolyW-1:0] HalfQ16    = 22'd32768;
  localparam logic [18:0]      CoefSquare = 19'd443023;  // 6.76 in Q.16
  localparam logic [17:0]      CoefLinear = 18'd209060;  // 3.19 in Q.16
  localparam logic [2:0]       CoefCube   = 3'd5;
  localparam logic [MuW-1:0]   MuOne      = 16'd4096;
  localparam logic [3:0]       TenC       = 4'd10;
  localparam logic [3:0]       RangeScale = 4'd14;        // 10 * 1.4

  localparam logic signed [TempW-1:0] UpperReset = 16'sd128;
  localparam logic signed [TempW-1:0] LowerReset = -16'sd128;
  localparam logic [MinW-1:0]         MinReset   = 20'd10;

  typedef struct packed {
    logic signed [TempW-1:0] temperature;
    logic [AmtW-1:0]         precip;
    logic [MuW-1:0]          precip_mu;
  } item_t;

  typedef struct packed {
    logic [AmtW-1:0] rain_amount;
    logic [AmtW-1:0] snow_amount;
    logic            config_error;
  } result_t;

  typedef struct packed {
    logic            err;
    logic            mode;
    logic            fixed;      // fraction is not divided out
    logic            fixed_one;  // fixed fraction is one, else zero
    logic            neg;        // Kienzle x <= 0
    logic            clamp;      // Kienzle |x| saturates at one
    logic [AmtW-1:0] precip;
    logic [MuW-1:0]  precip_mu;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } front_t;

  typedef struct packed {
    side_t           side;
    logic [DivW-1:0] rem;
    logic [DivW-1:0] den;
    logic [QuoW-1:0] quo;
  } divs_t;

  // one restoring step: {quotient bit, new remainder}, needs rem < den
  function automatic logic [DivW:0] div_step(input logic [DivW-1:0] rem,
                                             input logic [DivW-1:0] den);
    logic [DivW:0] r2;
    logic [DivW:0] diff;
    r2   = {rem, 1'b0};
    diff = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      return {1'b1, diff[DivW-1:0]};
    end
    return {1'b0, r2[DivW-1:0]};
  endfunction

endpackage

[hw/rtl/rsp_front.sv]
// ---------------------------------------------------------------------------
// rsp_front
// Entry stage: threshold checks, ramp / S-curve argument and divider operands.
// ---------------------------------------------------------------------------
module rsp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mode,
  input  logic signed [rsp_pkg::TempW-1:0] upper_temp,
  input  logic signed [rsp_pkg::TempW-1:0] lower_temp,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  rsp_pkg::item_t                item,
  output logic                          stage_valid,
  input  logic                          stage_ready,
  output rsp_pkg::front_t               stage
);
  import rsp_pkg::*;

  logic signed [TempW:0] t_ext;
  logic signed [TempW:0] up_ext;
  logic signed [TempW:0] lo_ext;
  logic signed [TempW:0] d_t;
  logic signed [TempW:0] t_lo;
  logic signed [TempW:0] up_lo;
  logic [TempW:0]        d_abs;
  logic [MinW-1:0]       mag_ten;
  logic [DivW-1:0]       den14;
  logic                  in_ramp;
  front_t                stage_next;

  always_comb begin
    t_ext   = {item.temperature[TempW-1], item.temperature};
    up_ext  = {upper_temp[TempW-1], upper_temp};
    lo_ext  = {lower_temp[TempW-1], lower_temp};
    d_t     = t_ext - up_ext;
    t_lo    = t_ext - lo_ext;
    up_lo   = up_ext - lo_ext;
    d_abs   = d_t[TempW] ? -d_t : d_t;
    mag_ten = {4'b0, d_abs[TempW-1:0]} * {16'b0, TenC};
    den14   = {4'b0, lower_temp[TempW-2:0]} * {15'b0, RangeScale};
    in_ramp = (t_ext > lo_ext) && (t_ext < up_ext);

    stage_next.side.mode      = mode;
    stage_next.side.neg       = (d_t <= 0);
    stage_next.side.clamp     = (mag_ten >= {1'b0, den14});
    stage_next.side.precip    = item.precip;
    stage_next.side.precip_mu = item.precip_mu;
    stage_next.side.fixed_one = (t_ext >= up_ext);
    if (!mode) begin
      stage_next.side.err   = (up_ext <= lo_ext);
      stage_next.side.fixed = !in_ramp;
      stage_next.num        = {3'b0, t_lo[TempW-1:0]};
      stage_next.den        = {3'b0, up_lo[TempW-1:0]};
    end else begin
      stage_next.side.err   = (lo_ext <= 0);
      stage_next.side.fixed = 1'b0;
      stage_next.num        = stage_next.side.clamp ? '0 : mag_ten[DivW-1:0];
      stage_next.den        = den14;
    end
    // keep the divider on legal operands when its answer is not used
    if (stage_next.side.err || stage_next.side.fixed) begin
      stage_next.num = '0;
      stage_next.den = DivW'(1);
    end
  end

  assign item_ready = !stage_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
    if (item_ready) begin
      stage <= stage_next;
    end
  end

endmodule

[hw/rtl/rsp_div.sv]
// ---------------------------------------------------------------------------
// rsp_div
// Pipelined restoring divider, two quotient bits per stage.
// ---------------------------------------------------------------------------
module rsp_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  rsp_pkg::front_t up,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rsp_pkg::divs_t  dn
);
  import rsp_pkg::*;

  divs_t st      [DivStages];
  divs_t st_next [DivStages];
  logic  vld     [DivStages];
  logic  rdy     [DivStages];

  always_comb begin
    divs_t       cur;
    logic [DivW:0] step;
    for (int s = 0; s < DivStages; s++) begin
      if (s == 0) begin
        cur.side = up.side;
        cur.rem  = up.num;
        cur.den  = up.den;
        cur.quo  = '0;
      end else begin
        cur = st[s-1];
      end
      for (int b = 0; b < BitsPerStage; b++) begin
        step    = div_step(cur.rem, cur.den);
        cur.rem = step[DivW-1:0];
        cur.quo = {cur.quo[QuoW-2:0], step[DivW]};
      end
      st_next[s] = cur;
    end
  end

  always_comb begin
    for (int s = 0; s < DivStages; s++) begin
      if (s == DivStages - 1) begin
        rdy[s] = !vld[s] || dn_ready;
      end else begin
        rdy[s] = !vld[s] || rdy[s+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DivStages; s++) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= (s == 0) ? up_valid : vld[(s == 0) ? 0 : s-1];
      end
      if (rdy[s]) begin
        st[s] <= st_next[s];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld[DivStages-1];
  assign dn       = st[DivStages-1];

endmodule

[hw/rtl/rsp_back.sv]
// ---------------------------------------------------------------------------
// rsp_back
// S-curve polynomial, amount scaling, small-part snapping and output word.
// ---------------------------------------------------------------------------
module rsp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rsp_pkg::MinW-1:0]     min_amount,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  rsp_pkg::divs_t               up,
  output logic                         result_valid,
  input  logic                         result_stall,
  output rsp_pkg::result_t             result
);
  import rsp_pkg::*;

  // stage 1: fraction or |x|, x^2, linear term
  side_t           s1;
  logic [FracW-1:0] a1;
  logic [FracW-1:0] x2_1;
  logic [18:0]      c3_1;
  // stage 2: x^3, square term
  side_t           s2;
  logic [FracW-1:0] a2;
  logic [FracW-1:0] x3_2;
  logic [19:0]      c2_2;
  logic [18:0]      c3_2;
  // stage 3: final fraction
  side_t           s3;
  logic [FracW-1:0] frac3;
  // stage 4: raw rain
  side_t           s4;
  logic [AmtW-1:0]  rain4;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r5;

  logic [FracW-1:0]     a_next;
  logic [2*FracW-1:0]   sq;
  logic [FracW+17:0]    lin;
  logic [2*FracW-1:0]   cube;
  logic [FracW+18:0]    sqc;
  logic [18:0]          c1;
  logic signed [PolyW-1:0] f_sum;
  logic [FracW-1:0]     frac_next;
  logic [FracW+AmtW-1:0] prod;
  logic [AmtW-1:0]      rain;
  logic [AmtW-1:0]      snow_raw;

  always_comb begin
    if (up.side.fixed) begin
      a_next = up.side.fixed_one ? FracOne : '0;
    end else if (up.side.mode && up.side.clamp) begin
      a_next = FracOne;
    end else begin
      a_next = {1'b0, up.quo};
    end
    sq   = a_next * a_next;
    lin  = {1'b0, a_next} * {17'b0, CoefLinear};
    cube = x2_1 * a1;
    sqc  = {2'b0, x2_1} * {17'b0, CoefSquare};
    c1   = {2'b0, x3_2} * {16'b0, CoefCube};
    if (s2.neg) begin
      f_sum = $signed(HalfQ16) - $signed({3'b0, c1}) + $signed({2'b0, c2_2})
            - $signed({3'b0, c3_2});
    end else begin
      f_sum = $signed(HalfQ16) + $signed({3'b0, c1}) - $signed({2'b0, c2_2})
            + $signed({3'b0, c3_2});
    end
    if (!s2.mode) begin
      frac_next = a2;
    end else if (f_sum < 0) begin
      frac_next = '0;
    end else if (f_sum > $signed({5'b0, FracOne})) begin
      frac_next = FracOne;
    end else begin
      frac_next = f_sum[FracW-1:0];
    end
    prod = frac3 * s3.precip;
    // snapping rules, in order
    rain = rain4;
    if (rain < {12'b0, min_amount}) begin
      rain = '0;
    end
    snow_raw = s4.precip - rain;
    if (snow_raw < {12'b0, min_amount}) begin
      rain = s4.precip;
    end
    if (s4.precip_mu < MuOne) begin
      rain = s4.precip;
    end
  end

  assign r5       = !result_valid || !result_stall;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign up_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) result_valid <= v4;
    end
    if (r1) begin
      s1   <= up.side;
      a1   <= a_next;
      x2_1 <= sq[FracW+15:16];
      c3_1 <= lin[34:16];
    end
    if (r2) begin
      s2   <= s1;
      a2   <= a1;
      x3_2 <= cube[FracW+15:16];
      c2_2 <= sqc[35:16];
      c3_2 <= c3_1;
    end
    if (r3) begin
      s3    <= s2;
      frac3 <= frac_next;
    end
    if (r4) begin
      s4    <= s3;
      rain4 <= prod[AmtW+15:16];
    end
    if (r5) begin
      if (s4.err) begin
        result.rain_amount <= '0;
        result.snow_amount <= '0;
      end else begin
        result.rain_amount <= rain;
        result.snow_amount <= s4.precip - rain;
      end
      result.config_error <= s4.err;
    end
  end

endmodule

[hw/rtl/rain_snow_partition_top.sv]
// ---------------------------------------------------------------------------
// rain_snow_partition_top
// Splits precipitation into rain and snow parts from air temperature.
//
//   channel  signals                                 dir
//   item     item_valid, item_stall, item            in
//   result   result_valid, result_stall, result      out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// One word per cycle sustained while result_stall stays low; the path is one entry stage,
// eight divider stages (two quotient bits each), four polynomial/scaling
// stages and the output register.
// Reset is synchronous and clears all valid bits and the configuration registers.
// Each stage advances when empty or when the next one advances, so bubbles
// close up behind a stalled result.
// ---------------------------------------------------------------------------
module rain_snow_partition_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  rsp_pkg::item_t           item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output rsp_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [rsp_pkg::MinW-1:0] cfg_data
);
  import rsp_pkg::*;

  logic                     mode;
  logic signed [TempW-1:0]  upper_temp;
  logic signed [TempW-1:0]  lower_temp;
  logic [MinW-1:0]          min_amount;

  logic   item_ready;
  logic   fr_valid, fr_ready;
  front_t fr;
  logic   dv_valid, dv_ready;
  divs_t  dv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      upper_temp <= UpperReset;
      lower_temp <= LowerReset;
      min_amount <= MinReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegMode:  mode       <= cfg_data[0];
        RegUpper: upper_temp <= cfg_data[TempW-1:0];
        RegLower: lower_temp <= cfg_data[TempW-1:0];
        RegMin:   min_amount <= cfg_data;
        default:  ;
      endcase
    end
  end

  rsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .upper_temp  (upper_temp),
    .lower_temp  (lower_temp),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .stage_valid (fr_valid),
    .stage_ready (fr_ready),
    .stage       (fr)
  );

  rsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up       (fr),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn       (dv)
  );

  rsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .min_amount   (min_amount),
    .up_valid     (dv_valid),
    .up_ready     (dv_ready),
    .up           (dv),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign item_stall = !item_ready;

  // empty output means every stage can move
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled with output register empty");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.config_error |->
      result.rain_amount == '0 && result.snow_amount == '0)
    else $error("nonzero amounts on config error");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_pipe_full_stall: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> fr_valid && !fr_ready)
    else $error("stall without a blocked entry stage");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for rain_snow_partition_top: a predictor computes the
// expected rain/snow split for every accepted word, a monitor compares the
// results in order. Runs directed corners, then random words over several
// register settings with random input gaps and random result stalls.
// ---------------------------------------------------------------------------
module tb_top;
  import rsp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = RegMode;
  logic [MinW-1:0] cfg_data = '0;

  rain_snow_partition_top uut (.*);

  always #4 clk = ~clk;

  // predictor copy of the registers
  logic p_mode;
  logic signed [15:0] p_upper, p_lower;
  logic [MinW-1:0] p_min;

  item_t pending_words[$];
  result_t expected_splits[$];
  int mismatches = 0;
  int hold_cycles = 0;

  function automatic longint unsigned kienzle_fraction(int t, int tt, int tr);
    int d;
    longint unsigned mag, den, a, x2, x3;
    longint c1, c2, c3, f;
    d = t - tt;
    mag = (d < 0) ? -d : d;
    den = 14 * tr;
    if (mag * 10 >= den) a = 65536;
    else a = (mag * 10 * 65536) / den;
    x2 = (a * a) >> 16;
    x3 = (x2 * a) >> 16;
    c1 = 5 * x3;
    c2 = (443023 * x2) >> 16;
    c3 = (209060 * a) >> 16;
    if (d <= 0) f = 32768 - c1 + c2 - c3;
    else f = 32768 + c1 - c2 + c3;
    if (f < 0) f = 0;
    if (f > 65536) f = 65536;
    return f;
  endfunction

  function automatic result_t predict_split(item_t w);
    result_t r;
    int t, up, lo;
    longint unsigned frac, rain, prec;
    t = w.temperature;
    up = p_upper;
    lo = p_lower;
    prec = w.precip;
    r = '0;
    if ((!p_mode && up <= lo) || (p_mode && lo <= 0)) begin
      r.config_error = 1'b1;
      return r;
    end
    if (!p_mode) begin
      if (t > lo && t < up) frac = (longint'(t - lo) * 65536) / (up - lo);
      else if (t >= up) frac = 65536;
      else frac = 0;
    end else begin
      frac = kienzle_fraction(t, up, lo);
    end
    rain = (frac * prec) >> 16;
    if (rain < p_min) rain = 0;
    if (prec - rain < p_min) rain = prec;
    if (w.precip_mu < MuOne) rain = prec;
    r.rain_amount = rain[31:0];
    r.snow_amount = prec[31:0] - rain[31:0];
    return r;
  endfunction

  // low for one cycle after a word was taken
  logic item_stall_q = 1'b0;

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall_q) begin
        if (pending_words.size() > 0 && send_gap == 0) begin
          item <= pending_words.pop_front();
          send_gap = $urandom_range(0, 8) * ($urandom_range(0, 3) == 0);
        end else begin
          item_valid <= 1'b0;
        end
      end else if (!item_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_words.size() > 0) begin
          item <= pending_words.pop_front();
          item_valid <= 1'b1;
          send_gap = $urandom_range(0, 8) * ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  // acceptance seen at posedge feeds the predictor
  always @(posedge clk) begin
    item_stall_q <= !(!rst && item_valid && !item_stall);
    if (!rst && item_valid && !item_stall) begin
      expected_splits.push_back(predict_split(item));
    end
  end

  // receiver stall
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(0, 8);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_splits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        e = expected_splits.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rain %h snow %h err %b, got rain %h snow %h err %b",
                     e.rain_amount, e.snow_amount, e.config_error,
                     result.rain_amount, result.snow_amount, result.config_error);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [MinW-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegMode:  p_mode = val[0];
      RegUpper: p_upper = val[15:0];
      RegLower: p_lower = val[15:0];
      default:  p_min = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || item_valid || expected_splits.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic item_t random_word();
    item_t w;
    w.temperature = $urandom();
    if ($urandom_range(0, 2) == 0) w.temperature = $urandom_range(0, 3000) - 1500;
    case ($urandom_range(0, 3))
      0: w.precip = $urandom_range(0, 40);
      1: w.precip = $urandom_range(0, 1 << 22);
      default: w.precip = $urandom();
    endcase
    w.precip_mu = ($urandom_range(0, 4) == 0) ? $urandom() : 16'd4096 + $urandom_range(0, 100);
    return w;
  endfunction

  task automatic queue_word(logic signed [15:0] t, logic [31:0] p, logic [15:0] mu);
    item_t w;
    w.temperature = t;
    w.precip = p;
    w.precip_mu = mu;
    pending_words.push_back(w);
  endtask

  initial begin
    int k;
    p_mode = 1'b0;
    p_upper = UpperReset;
    p_lower = LowerReset;
    p_min = MinReset;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: reset settings, linear ramp corners and snap rules
    queue_word(-16'sd32768, 32'hFFFFFFFF, 16'd4096);
    queue_word(16'sd32767, 32'hFFFFFFFF, 16'hFFFF);
    queue_word(-16'sd128, 32'd1000, 16'd4096);
    queue_word(16'sd128, 32'd1000, 16'd4096);
    queue_word(16'sd0, 32'd1000, 16'd4096);
    queue_word(16'sd0, 32'd15, 16'd4096);
    queue_word(16'sd127, 32'd3000, 16'd4096);
    queue_word(-16'sd127, 32'd3000, 16'd4096);
    queue_word(-16'sd500, 32'd1000, 16'd4095);
    queue_word(16'sd0, 32'd0, 16'd0);
    wait_drained();
    // Kienzle, valid range
    write_reg(RegMode, 1);
    write_reg(RegUpper, 20'd256);
    write_reg(RegLower, 20'd512);
    queue_word(16'sd256, 32'h00100000, 16'd4096);
    queue_word(16'sd257, 32'h00100000, 16'd4096);
    queue_word(16'sd2000, 32'h00100000, 16'd4096);
    queue_word(-16'sd2000, 32'h00100000, 16'd4096);
    queue_word(16'sd32767, 32'hFFFFFFFF, 16'd4096);
    queue_word(-16'sd32768, 32'hFFFFFFFF, 16'd4096);
    for (k = 0; k < 200; k++) pending_words.push_back(random_word());
    hold_cycles = 200;   // long receiver hold backs the pipe up
    wait_drained();
    // Kienzle with invalid range
    write_reg(RegLower, 20'hF0000);
    queue_word(16'sd0, 32'd5000, 16'd4096);
    for (k = 0; k < 50; k++) pending_words.push_back(random_word());
    wait_drained();
    // linear, invalid then extremes
    write_reg(RegMode, 0);
    write_reg(RegUpper, 20'd100);
    write_reg(RegLower, 20'd100);
    queue_word(16'sd0, 32'd5000, 16'd4096);
    wait_drained();
    write_reg(RegUpper, 20'h07FFF);
    write_reg(RegLower, 20'h08000);
    write_reg(RegMin, 20'hFFFFF);
    for (k = 0; k < 200; k++) pending_words.push_back(random_word());
    wait_drained();
    write_reg(RegMin, 20'd0);
    write_reg(RegUpper, 20'd640);
    write_reg(RegLower, 20'hFFE00);
    for (k = 0; k < 200; k++) pending_words.push_back(random_word());
    wait_drained();
    write_reg(RegMode, 1);
    write_reg(RegUpper, 20'hFFF00);
    write_reg(RegLower, 20'd1);
    write_reg(RegMin, 20'd300);
    for (k = 0; k < 150; k++) pending_words.push_back(random_word());
    wait_drained();
    write_reg(RegUpper, 20'd0);
    write_reg(RegLower, 20'h07FFF);
    for (k = 0; k < 130; k++) pending_words.push_back(random_word());
    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule

[rain_snow_partition_top.f]
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_front.sv
hw/rtl/rsp_div.sv
hw/rtl/rsp_back.sv
hw/rtl/rain_snow_partition_top.sv
tb/sv/tb_top.sv
